### rtl/gtid_pkg.sv
`default_nettype none
package gtid_pkg;

   localparam int RateWidth  = 16;
   localparam int AngleWidth = 32;
   localparam int LedWidth   = 8;
   localparam int SensWidth  = 24;
   localparam int StepWidth  = 16;
   localparam int DeadWidth  = 16;
   localparam int ThrWidth   = 31;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 32;
   localparam int MulAWidth  = 31;
   localparam int MulBWidth  = 24;
   localparam int MulPWidth  = MulAWidth + MulBWidth;
   localparam int FracShift  = 24;
   localparam int NumAxes    = 3;

   localparam logic [SensWidth-1:0] SensReset = 24'd293601;
   localparam logic [StepWidth-1:0] StepReset = 16'd6881;
   localparam logic [DeadWidth-1:0] DeadReset = 16'd1311;
   localparam logic [ThrWidth-1:0]  ThrReset  = 31'd655360;

   localparam logic [CsrIdxWidth-1:0] CsrSensitivity = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrStepTime    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrDeadband    = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrThreshold   = 2'd3;

   localparam logic [LedWidth-1:0] LedNone   = 8'h00;
   localparam logic [LedWidth-1:0] LedNxNy   = 8'h01;
   localparam logic [LedWidth-1:0] LedNx     = 8'h02;
   localparam logic [LedWidth-1:0] LedNxPy   = 8'h04;
   localparam logic [LedWidth-1:0] LedPy     = 8'h08;
   localparam logic [LedWidth-1:0] LedPxPy   = 8'h10;
   localparam logic [LedWidth-1:0] LedPx     = 8'h20;
   localparam logic [LedWidth-1:0] LedPxNy   = 8'h40;
   localparam logic [LedWidth-1:0] LedNy     = 8'h80;

   localparam logic [1:0] LastAxis = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_STEP,
      ST_MUL_SENS,
      ST_ACCUM,
      ST_DIRECT
   } gtid_state_type;

   typedef enum logic [0:0] {
      MUL_SEL_STEP,
      MUL_SEL_SENS
   } gtid_mul_sel_type;

endpackage
`default_nettype wire

### rtl/gtid_ifs.sv
`default_nettype none
interface gtid_req_if import gtid_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [RateWidth-1:0] rate_x;
   logic signed [RateWidth-1:0] rate_y;
   logic signed [RateWidth-1:0] rate_z;

   modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
   modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gtid_rsp_if import gtid_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [AngleWidth-1:0] angle_x;
   logic signed [AngleWidth-1:0] angle_y;
   logic signed [AngleWidth-1:0] angle_z;
   logic        [LedWidth-1:0]   led_pattern;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   output led_pattern, input ready);
   modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                   input led_pattern, output ready);
endinterface

interface gtid_csr_if import gtid_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CsrIdxWidth-1:0]  index;
   logic [CsrDataWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/gyro_tilt_integrator_direction_unit.sv
// Gyro rate integrator with deadband and eight-way tilt direction indicator.
// The req_if channel takes one word of three signed 16-bit rate samples.
// The rsp_if channel returns one word per request: the three saturated
// Q15.16 angles after the update and a one-hot tilt direction pattern.
// The csr_if channel writes sensitivity, step time, deadband and threshold;
// it is always ready and should be written only while the unit is idle.
// One shared 31x24 multiplier is used twice per axis: each axis passes
// through a step-time multiply, a sensitivity multiply and an accumulate
// state, and a direction state follows. A new request is taken only in
// the idle state, after the previous response has entered the output register.
// The response sits in an output register; while the receiver stalls the
// unit still accepts and processes the next request, then waits to load
// the new response until the previous one has been taken.
// Reset clears all angles, loads the default register values and empties
// the output register.
`default_nettype none
module gyro_tilt_integrator_direction_unit import gtid_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   gtid_req_if.sink     req_if,
   gtid_rsp_if.source   rsp_if,
   gtid_csr_if.sink     csr_if
);

   gtid_state_type state_ff, state_in;
   logic [1:0]     axis_ff, axis_in;

   logic signed [RateWidth-1:0]  rate_ff [NumAxes];
   logic signed [AngleWidth-1:0] angle_ff [NumAxes];
   logic signed [AngleWidth-1:0] angle_in;
   logic [MulPWidth-1:0]         prod_ff;

   logic [SensWidth-1:0] sens_ff;
   logic [StepWidth-1:0] step_ff;
   logic [DeadWidth-1:0] dead_ff;
   logic [ThrWidth-1:0]  thr_ff;

   logic                         rsp_valid_ff;
   logic signed [AngleWidth-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [LedWidth-1:0]          rsp_led_ff, led_in;

   gtid_mul_sel_type     mul_sel;
   logic                 load_req, load_prod, load_angle, load_rsp, out_free;
   logic                 req_take;
   logic [MulAWidth-1:0] mul_a;
   logic [MulBWidth-1:0] mul_b;
   logic [MulPWidth-1:0] mul_p;

   logic signed [RateWidth-1:0] rate_sel;
   logic [RateWidth-1:0]        rate_mag;
   logic [ThrWidth-1:0]         inc;
   logic signed [AngleWidth:0]  sum;

   logic signed [AngleWidth-1:0] ang_x, ang_y;
   logic [AngleWidth-1:0]        ax, ay;
   logic [AngleWidth:0]          two_ax;
   logic [AngleWidth+1:0]        three_ay;
   logic                         lit, diag, x_pos, y_pos;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign req_take           = req_if.valid && req_if.ready;
   assign csr_if.ready       = 1'b1;
   assign out_free           = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.angle_x     = rsp_x_ff;
   assign rsp_if.angle_y     = rsp_y_ff;
   assign rsp_if.angle_z     = rsp_z_ff;
   assign rsp_if.led_pattern = rsp_led_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MUL_STEP;
               axis_in  = 2'd0;
            end
         end
         ST_MUL_STEP: state_in = ST_MUL_SENS;
         ST_MUL_SENS: state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (axis_ff == LastAxis) begin
               state_in = ST_DIRECT;
            end else begin
               state_in = ST_MUL_STEP;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_DIRECT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      mul_sel    = MUL_SEL_STEP;
      load_req   = 1'b0;
      load_prod  = 1'b0;
      load_angle = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:     load_req = req_take;
         ST_MUL_STEP: load_prod = 1'b1;
         ST_MUL_SENS: begin
            mul_sel   = MUL_SEL_SENS;
            load_prod = 1'b1;
         end
         ST_ACCUM:    load_angle = 1'b1;
         ST_DIRECT:   load_rsp = out_free;
         default:     load_req = 1'b0;
      endcase
   end

   // Shared multiplier: first |rate| * step_time, then that * sensitivity.
   assign rate_sel = rate_ff[axis_ff];
   assign rate_mag = rate_sel[RateWidth-1] ? (~rate_sel + 1'b1) : rate_sel;

   always_comb begin
      case (mul_sel)
         MUL_SEL_STEP: begin
            mul_a = {{(MulAWidth-RateWidth){1'b0}}, rate_mag};
            mul_b = {{(MulBWidth-StepWidth){1'b0}}, step_ff};
         end
         MUL_SEL_SENS: begin
            mul_a = prod_ff[MulAWidth-1:0];
            mul_b = sens_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {{MulBWidth{1'b0}}, mul_a} * {{MulAWidth{1'b0}}, mul_b};

   // Deadband test and saturating accumulate.
   assign inc = prod_ff[FracShift +: ThrWidth];
   assign sum = rate_sel[RateWidth-1]
              ? {angle_ff[axis_ff][AngleWidth-1], angle_ff[axis_ff]} - {2'b00, inc}
              : {angle_ff[axis_ff][AngleWidth-1], angle_ff[axis_ff]} + {2'b00, inc};

   always_comb begin
      if (inc <= {{(ThrWidth-DeadWidth){1'b0}}, dead_ff}) begin
         angle_in = angle_ff[axis_ff];
      end else if (sum[AngleWidth] != sum[AngleWidth-1]) begin
         angle_in = sum[AngleWidth] ? {1'b1, {(AngleWidth-1){1'b0}}}
                                    : {1'b0, {(AngleWidth-1){1'b1}}};
      end else begin
         angle_in = sum[AngleWidth-1:0];
      end
   end

   // Tilt direction from the X and Y angles.
   assign ang_x    = angle_ff[0];
   assign ang_y    = angle_ff[1];
   assign ax       = ang_x[AngleWidth-1] ? (~ang_x + 1'b1) : ang_x;
   assign ay       = ang_y[AngleWidth-1] ? (~ang_y + 1'b1) : ang_y;
   assign two_ax   = {ax, 1'b0};
   assign three_ay = {1'b0, ay, 1'b0} + {2'b00, ay};
   assign lit      = (ax > {1'b0, thr_ff}) || (ay > {1'b0, thr_ff});
   assign diag     = (two_ax > {1'b0, ay}) && ({1'b0, two_ax} < three_ay);
   assign x_pos    = !ang_x[AngleWidth-1] && (ang_x != '0);
   assign y_pos    = !ang_y[AngleWidth-1] && (ang_y != '0);

   always_comb begin
      if (!lit) begin
         led_in = LedNone;
      end else if (diag) begin
         if (x_pos) begin
            led_in = y_pos ? LedPxPy : LedPxNy;
         end else begin
            led_in = y_pos ? LedNxPy : LedNxNy;
         end
      end else if (ax > ay) begin
         led_in = x_pos ? LedPx : LedNx;
      end else begin
         led_in = y_pos ? LedPy : LedNy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         sens_ff      <= SensReset;
         step_ff      <= StepReset;
         dead_ff      <= DeadReset;
         thr_ff       <= ThrReset;
         for (int i = 0; i < NumAxes; i++) begin
            angle_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_if.valid) begin
            case (csr_if.index)
               CsrSensitivity: sens_ff <= csr_if.data[SensWidth-1:0];
               CsrStepTime:    step_ff <= csr_if.data[StepWidth-1:0];
               CsrDeadband:    dead_ff <= csr_if.data[DeadWidth-1:0];
               CsrThreshold:   thr_ff  <= csr_if.data[ThrWidth-1:0];
               default:        thr_ff  <= thr_ff;
            endcase
         end
         if (load_angle) begin
            angle_ff[axis_ff] <= angle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         rate_ff[0] <= req_if.rate_x;
         rate_ff[1] <= req_if.rate_y;
         rate_ff[2] <= req_if.rate_z;
      end
      if (load_prod) begin
         prod_ff <= mul_p;
      end
      if (load_rsp) begin
         rsp_x_ff   <= angle_ff[0];
         rsp_y_ff   <= angle_ff[1];
         rsp_z_ff   <= angle_ff[2];
         rsp_led_ff <= led_in;
      end
   end

endmodule
`default_nettype wire

### tb/sv/gtid_angle_check.sv
`timescale 1ns / 100ps
module gtid_angle_check import gtid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gtid_req_if         req,
   gtid_rsp_if         rsp,
   gtid_csr_if         csr,
   output int unsigned mismatches,
   output int unsigned pending,
   output int unsigned words_checked
);

   localparam longint AngleMax = (longint'(1) << (AngleWidth - 1)) - 1;
   localparam longint AngleMin = -(longint'(1) << (AngleWidth - 1));
   localparam int     ReportLimit = 10;

   typedef struct packed {
      logic signed [AngleWidth-1:0] angle_x;
      logic signed [AngleWidth-1:0] angle_y;
      logic signed [AngleWidth-1:0] angle_z;
      logic        [LedWidth-1:0]   led;
   } tilt_word_type;

   logic [SensWidth-1:0]         sens_q;
   logic [StepWidth-1:0]         step_q;
   logic [DeadWidth-1:0]         dead_q;
   logic [ThrWidth-1:0]          thr_q;
   logic signed [AngleWidth-1:0] angle_q [NumAxes];
   tilt_word_type                expected_q [$];
   int unsigned                  fail_count;
   int unsigned                  compared;

   function automatic logic signed [AngleWidth-1:0] integrate(
      input logic signed [AngleWidth-1:0] angle,
      input logic signed [RateWidth-1:0]  rate
   );
      longint mag;
      longint inc;
      longint acc;
      mag = longint'(rate);
      if (mag < 0) begin
         mag = -mag;
      end
      inc = (mag * longint'(sens_q) * longint'(step_q)) >>> FracShift;
      if (inc <= longint'(dead_q)) begin
         return angle;
      end
      acc = longint'(angle) + ((rate < 0) ? -inc : inc);
      if (acc > AngleMax) begin
         acc = AngleMax;
      end
      if (acc < AngleMin) begin
         acc = AngleMin;
      end
      return AngleWidth'(acc);
   endfunction

   function automatic logic [LedWidth-1:0] tilt_direction(
      input logic signed [AngleWidth-1:0] x,
      input logic signed [AngleWidth-1:0] y
   );
      longint ax;
      longint ay;
      ax = longint'(x);
      ay = longint'(y);
      if (ax < 0) begin
         ax = -ax;
      end
      if (ay < 0) begin
         ay = -ay;
      end
      if (!(ax > longint'(thr_q) || ay > longint'(thr_q))) begin
         return LedNone;
      end
      if (2 * ax > ay && 2 * ax < 3 * ay) begin
         if (x > 0) begin
            return (y > 0) ? LedPxPy : LedPxNy;
         end
         return (y > 0) ? LedNxPy : LedNxNy;
      end
      if (ax > ay) begin
         return (x > 0) ? LedPx : LedNx;
      end
      return (y > 0) ? LedPy : LedNy;
   endfunction

   always @(posedge clock) begin
      tilt_word_type want;
      tilt_word_type got;
      if (reset) begin
         sens_q = SensReset;
         step_q = StepReset;
         dead_q = DeadReset;
         thr_q  = ThrReset;
         for (int k = 0; k < NumAxes; k++) begin
            angle_q[k] = '0;
         end
         expected_q.delete();
         fail_count = 0;
         compared   = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CsrSensitivity: sens_q = csr.data[SensWidth-1:0];
               CsrStepTime:    step_q = csr.data[StepWidth-1:0];
               CsrDeadband:    dead_q = csr.data[DeadWidth-1:0];
               CsrThreshold:   thr_q  = csr.data[ThrWidth-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            angle_q[0] = integrate(angle_q[0], req.rate_x);
            angle_q[1] = integrate(angle_q[1], req.rate_y);
            angle_q[2] = integrate(angle_q[2], req.rate_z);
            want = '{angle_q[0], angle_q[1], angle_q[2],
                     tilt_direction(angle_q[0], angle_q[1])};
            expected_q.push_back(want);
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.angle_x, rsp.angle_y, rsp.angle_z, rsp.led_pattern};
            if (expected_q.size() == 0) begin
               if (fail_count < ReportLimit) begin
                  $display("%0t: response word with no request outstanding:", $time);
                  $display("   actual   x=%0d y=%0d z=%0d led=%02h",
                           got.angle_x, got.angle_y, got.angle_z, got.led);
               end
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.angle_x !== want.angle_x || got.angle_y !== want.angle_y ||
                   got.angle_z !== want.angle_z || got.led !== want.led) begin
                  if (fail_count < ReportLimit) begin
                     $display("%0t: response word %0d mismatch", $time, compared);
                     $display("   expected x=%0d y=%0d z=%0d led=%02h",
                              want.angle_x, want.angle_y, want.angle_z, want.led);
                     $display("   actual   x=%0d y=%0d z=%0d led=%02h",
                              got.angle_x, got.angle_y, got.angle_z, got.led);
                  end
                  fail_count++;
               end
            end
            compared++;
         end
      end
      mismatches    <= fail_count;
      pending       <= expected_q.size();
      words_checked <= compared;
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
   import gtid_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int RandomPhases  = 10;
   localparam int ItemsPerPhase = 105;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycles = 0;
   int unsigned mismatches;
   int unsigned pending;
   int unsigned words_checked;
   int unsigned words_sent = 0;
   int unsigned settings_used = 0;

   gtid_req_if req ();
   gtid_rsp_if rsp ();
   gtid_csr_if csr ();

   gyro_tilt_integrator_direction_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   gtid_angle_check angle_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr           (csr),
      .mismatches    (mismatches),
      .pending       (pending),
      .words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Timed out after %0d cycles with %0d words outstanding.", cycles, pending);
         $display("[gyro_tilt_integrator_direction_unit] ERROR");
         $finish;
      end
   end

   task automatic offer_rates(
      input logic signed [RateWidth-1:0] rx,
      input logic signed [RateWidth-1:0] ry,
      input logic signed [RateWidth-1:0] rz
   );
      req.valid  <= 1'b1;
      req.rate_x <= rx;
      req.rate_y <= ry;
      req.rate_z <= rz;
      do @(posedge clock); while (!req.ready);
      words_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(
      input logic [CsrIdxWidth-1:0]  idx,
      input logic [CsrDataWidth-1:0] value,
      input int                      width
   );
      logic [CsrDataWidth-1:0] keep;
      keep = CsrDataWidth'((64'd1 << width) - 1);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= (value & keep) | ($urandom() & ~keep);
      do @(posedge clock); while (!csr.ready);
   endtask

   task automatic write_settings(
      input logic [CsrDataWidth-1:0] sens,
      input logic [CsrDataWidth-1:0] step,
      input logic [CsrDataWidth-1:0] dead,
      input logic [CsrDataWidth-1:0] thr
   );
      write_reg(CsrSensitivity, sens, SensWidth);
      write_reg(CsrStepTime, step, StepWidth);
      write_reg(CsrDeadband, dead, DeadWidth);
      write_reg(CsrThreshold, thr, ThrWidth);
      csr.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [RateWidth-1:0] pick_rate();
      int style;
      logic signed [RateWidth-1:0] r;
      style = $urandom_range(0, 9);
      if (style < 6) begin
         r = RateWidth'($urandom());
      end else if (style < 8) begin
         r = RateWidth'($urandom_range(0, 600));
         if ($urandom_range(0, 1) == 1) begin
            r = -r;
         end
      end else begin
         case ($urandom_range(0, 4))
            0:       r = 16'sh8000;
            1:       r = 16'sh7FFF;
            2:       r = 16'sh0000;
            3:       r = -16'sd1;
            default: r = 16'sd1;
         endcase
      end
      return r;
   endfunction

   task automatic send_random_words(input int count);
      int burst;
      int gap;
      int mode;
      mode = $urandom_range(0, 2);
      while (count > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && count > 0) begin
            offer_rates(pick_rate(), pick_rate(), pick_rate());
            burst--;
            count--;
         end
         case (mode)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 3);
            default: gap = $urandom_range(0, 24);
         endcase
         if (gap > 0 && count > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
   endtask

   initial begin
      int  kind;
      int  span;
      int  stall_pct;
      bit  held_long;
      held_long = 1'b0;
      rsp.ready <= 1'b0;
      repeat (8) @(posedge clock);
      forever begin
         kind = $urandom_range(0, 19);
         if (!held_long && cycles > 2500) begin
            kind = 0;
         end
         if (kind == 0) begin
            span = $urandom_range(150, 300);
            rsp.ready <= 1'b0;
            repeat (span) @(posedge clock);
            held_long = 1'b1;
         end else if (kind < 8) begin
            span = $urandom_range(20, 200);
            rsp.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end else begin
            span      = $urandom_range(10, 120);
            stall_pct = $urandom_range(10, 85);
            repeat (span) begin
               rsp.ready <= ($urandom_range(1, 100) > stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      logic [CsrDataWidth-1:0] sens_w;
      logic [CsrDataWidth-1:0] step_w;
      logic [CsrDataWidth-1:0] dead_w;
      logic [CsrDataWidth-1:0] thr_w;
      req.valid  <= 1'b0;
      req.rate_x <= '0;
      req.rate_y <= '0;
      req.rate_z <= '0;
      csr.valid  <= 1'b0;
      csr.index  <= '0;
      csr.data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset values: zero input, words inside the deadband, then full-scale rates.
      offer_rates(16'sd0, 16'sd0, 16'sd0);
      offer_rates(16'sd1, -16'sd1, 16'sd10);
      offer_rates(16'sh7FFF, 16'sh8000, 16'sd11);
      req.valid <= 1'b0;

      // Full-scale settings drive every angle into both saturation limits.
      wait_drained();
      write_settings('1, '1, '1, '1);
      offer_rates(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      offer_rates(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      offer_rates(16'sh8000, 16'sh8000, 16'sh8000);
      offer_rates(16'sh8000, 16'sh8000, 16'sh8000);
      offer_rates(16'sh8000, 16'sh8000, 16'sh8000);
      req.valid <= 1'b0;

      // Walk every angle from the negative limit back to exactly zero.
      wait_drained();
      write_settings(32'h0080_0000, 32'h0000_8000, 32'd0, 32'h7FFF_FFFF);
      repeat (4) offer_rates(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      offer_rates(16'sd4, 16'sd4, 16'sd4);
      req.valid <= 1'b0;

      // One rate LSB now adds one angle LSB, so deadband and direction edges are exact.
      wait_drained();
      write_settings(32'h0001_0000, 32'h0000_0100, 32'd100, 32'h7FFF_FFFF);
      offer_rates(16'sd100, -16'sd100, 16'sd100);
      offer_rates(16'sd101, -16'sd101, -16'sd101);
      req.valid <= 1'b0;
      wait_drained();
      write_settings(32'h0001_0000, 32'h0000_0100, 32'd0, 32'd202);
      offer_rates(16'sd101, 16'sd0, 16'sd0);
      offer_rates(16'sd1, 16'sd0, 16'sd0);
      offer_rates(16'sd0, -16'sd305, 16'sd0);
      offer_rates(16'sd406, 16'sd0, 16'sd0);
      offer_rates(-16'sd1, 16'sd0, 16'sd0);
      offer_rates(-16'sd1216, 16'sd812, 16'sd0);
      offer_rates(16'sd0, -16'sd812, 16'sd0);
      offer_rates(16'sd1216, 16'sd1014, 16'sd0);
      offer_rates(-16'sd2000, 16'sd0, 16'sd0);
      offer_rates(16'sd1392, 16'sd1000, 16'sd0);
      req.valid <= 1'b0;

      for (int ph = 0; ph < RandomPhases; ph++) begin
         if (ph == 0) begin
            sens_w = '1;
            step_w = '1;
            dead_w = '1;
            thr_w  = '1;
         end else if (ph == 1) begin
            sens_w = '0;
            step_w = '0;
            dead_w = '0;
            thr_w  = '0;
         end else begin
            case ($urandom_range(0, 4))
               0:       sens_w = $urandom();
               1:       sens_w = SensReset;
               default: sens_w = $urandom_range(0, 1 << 20);
            endcase
            case ($urandom_range(0, 4))
               0:       step_w = $urandom();
               1:       step_w = StepReset;
               default: step_w = $urandom_range(0, 4096);
            endcase
            case ($urandom_range(0, 3))
               0:       dead_w = 0;
               1:       dead_w = DeadReset;
               default: dead_w = $urandom();
            endcase
            case ($urandom_range(0, 3))
               0:       thr_w = 0;
               1:       thr_w = $urandom();
               default: thr_w = $urandom_range(0, 1 << 24);
            endcase
         end
         wait_drained();
         write_settings(sens_w, step_w, dead_w, thr_w);
         send_random_words(ItemsPerPhase);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d rate words under %0d register settings; %0d response words compared.",
               words_sent, settings_used, words_checked);
      $display("Directed words covered saturation, deadband, threshold and all directions.");
      if (mismatches == 0 && pending == 0) begin
         $display("[gyro_tilt_integrator_direction_unit] OK");
      end else begin
         $display("[gyro_tilt_integrator_direction_unit] ERROR");
      end
      $finish;
   end

endmodule
